// File: src/tvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tvs_pkg;

  localparam int unsigned CRAM_AW = 11;
  localparam int unsigned VRAM_AW = 11;
  localparam int unsigned TRAM_AW = 12;
  localparam int unsigned PROM_AW = 5;
  localparam int unsigned PROM_DEPTH = 32;
  localparam int unsigned CRAM_DEPTH = 2048;
  localparam int unsigned VRAM_DEPTH = 2048;
  localparam int unsigned TRAM_DEPTH = 4096;

  localparam logic [7:0] RGB_W0 = 8'h21;
  localparam logic [7:0] RGB_W1 = 8'h47;
  localparam logic [7:0] RGB_W2 = 8'h97;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_PROM  = 2'd2,
    ACT_PIXEL = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RGN_NONE  = 2'd0,
    RGN_COLOR = 2'd1,
    RGN_VIDEO = 2'd2,
    RGN_TILE  = 2'd3
  } region_t;

  typedef struct packed {
    logic               we_color;
    logic               we_video;
    logic               we_tile;
    logic               re_color;
    logic               re_video;
    logic               re_tile;
    logic [CRAM_AW-1:0] addr_color;
    logic [VRAM_AW-1:0] addr_video;
    logic [TRAM_AW-1:0] addr_tile;
    logic [7:0]         wdata;
  } mem_req_t;

  function automatic region_t bus_region(input logic [15:0] addr);
    region_t rgn;
    rgn = RGN_NONE;
    if (addr[15:12] == 4'hF) begin
      rgn = RGN_TILE;
    end else if (addr[15:11] == 5'b11101) begin
      rgn = RGN_VIDEO;
    end else if (addr[15:11] == 5'b11100) begin
      rgn = RGN_COLOR;
    end
    return rgn;
  endfunction

  // resistor-weighted DAC, the weights sum to 8'hFF so the result fits in 8 bits
  function automatic logic [7:0] weigh(input logic b0, input logic b1, input logic b2);
    return ({8{b0}} & RGB_W0) + ({8{b1}} & RGB_W1) + ({8{b2}} & RGB_W2);
  endfunction

endpackage

`default_nettype wire

// File: src/tvs_vram.sv
`timescale 1ns / 1ps
`default_nettype none

module tvs_vram
  import tvs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mem_req_t req,
  output logic          clr_busy,
  output logic [7:0]    color_rd,
  output logic [7:0]    video_rd,
  output logic [7:0]    tile_rd
);

  logic [7:0] color_mem [CRAM_DEPTH];
  logic [7:0] video_mem [VRAM_DEPTH];
  logic [7:0] tile_mem  [TRAM_DEPTH];

  logic               clr_busy_r;
  logic [TRAM_AW-1:0] clr_cnt_r;
  logic [7:0]         color_rd_r;
  logic [7:0]         video_rd_r;
  logic [7:0]         tile_rd_r;

  // clearing sweep after reset, one address per cycle over all three RAMs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == TRAM_AW'(TRAM_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      color_mem[clr_cnt_r[CRAM_AW-1:0]] <= 8'h00;
    end else if (req.we_color) begin
      color_mem[req.addr_color] <= req.wdata;
    end
    if (req.re_color) begin
      color_rd_r <= color_mem[req.addr_color];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      video_mem[clr_cnt_r[VRAM_AW-1:0]] <= 8'h00;
    end else if (req.we_video) begin
      video_mem[req.addr_video] <= req.wdata;
    end
    if (req.re_video) begin
      video_rd_r <= video_mem[req.addr_video];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      tile_mem[clr_cnt_r] <= 8'h00;
    end else if (req.we_tile) begin
      tile_mem[req.addr_tile] <= req.wdata;
    end
    if (req.re_tile) begin
      tile_rd_r <= tile_mem[req.addr_tile];
    end
  end

  assign clr_busy = clr_busy_r;
  assign color_rd = color_rd_r;
  assign video_rd = video_rd_r;
  assign tile_rd  = tile_rd_r;

endmodule

`default_nettype wire

// File: src/tvs_palette.sv
`timescale 1ns / 1ps
`default_nettype none

module tvs_palette
  import tvs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [PROM_AW-1:0] waddr,
  input  wire logic [7:0]         wdata,
  input  wire logic [PROM_AW-1:0] ridx,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue
);

  logic [7:0] prom_r [PROM_DEPTH];
  logic [7:0] entry;

  always_ff @(posedge clk) begin
    if (we) begin
      prom_r[waddr] <= wdata;
    end
  end

  assign entry = prom_r[ridx];
  assign red   = weigh(entry[0], entry[1], entry[2]);
  assign green = weigh(entry[3], entry[4], entry[5]);
  assign blue  = weigh(1'b0, entry[6], entry[7]);

endmodule

`default_nettype wire

// File: src/tilemap_video_scanout_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: a read goes from the RAM read register to the output register in S_RD; a pixel
//   query reads video/color RAM, then tile RAM in S_TILE, then the palette in S_PAL.
// Throughput: one write or PROM load per cycle when in_stall is low; a read or pixel query
//   holds in_stall until its result is loaded. Reset: synchronous, active low; a clearing
//   pass zeroes color, video and tile RAM while in_stall is high. The color PROM is not cleared.

module tilemap_video_scanout_unit
  import tvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [7:0]  in_pixel_x,
  input  wire logic [7:0]  in_pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_TILE,
    S_PAL
  } state_t;

  state_t  state_r, state_nxt;
  logic    out_valid_r;
  logic [7:0] out_read_data_r, out_red_r, out_green_r, out_blue_r;
  region_t rgn_r;
  logic [2:0] x_r;
  logic [2:0] y_r;

  mem_req_t mreq;
  logic     clr_busy;
  logic [7:0] color_rd, video_rd, tile_rd;
  logic     prom_we;
  logic [PROM_AW-1:0] pal_idx;
  logic [7:0] pal_red, pal_green, pal_blue;

  action_t act;
  logic    in_acc;
  logic    out_free;
  logic    load_out;
  logic [4:0] row;
  logic [VRAM_AW-1:0] tile_pos;
  logic [7:0] rd_mux;
  logic [3:0] tb_hi, tb_lo;
  logic [1:0] sh;

  assign act      = action_t'(in_action);
  assign in_stall = clr_busy || (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = ((state_r == S_RD) || (state_r == S_PAL)) && out_free;

  assign row      = 5'((9'(in_pixel_y) + 9'd16) >> 3);
  assign tile_pos = {row, 1'b1, in_pixel_x[7:3]};

  always_comb begin
    mreq    = '0;
    prom_we = 1'b0;
    mreq.wdata      = in_write_data;
    mreq.addr_color = in_address[CRAM_AW-1:0];
    mreq.addr_video = in_address[VRAM_AW-1:0];
    mreq.addr_tile  = in_address[TRAM_AW-1:0];
    if (in_acc) begin
      case (act)
        ACT_WRITE: begin
          mreq.we_color = (bus_region(in_address) == RGN_COLOR);
          mreq.we_video = (bus_region(in_address) == RGN_VIDEO);
          mreq.we_tile  = (bus_region(in_address) == RGN_TILE);
        end
        ACT_READ: begin
          mreq.re_color = 1'b1;
          mreq.re_video = 1'b1;
          mreq.re_tile  = 1'b1;
        end
        ACT_PROM: begin
          prom_we = (in_address[15:PROM_AW] == '0);
        end
        ACT_PIXEL: begin
          mreq.re_video   = 1'b1;
          mreq.re_color   = 1'b1;
          mreq.addr_video = tile_pos;
          mreq.addr_color = {1'b0, tile_pos[10:7], tile_pos[5:0]};
        end
        default: begin
        end
      endcase
    end
    if (state_r == S_TILE) begin
      mreq.re_tile   = 1'b1;
      mreq.addr_tile = {video_rd, y_r, x_r[2]};
    end
  end

  always_comb begin
    case (rgn_r)
      RGN_COLOR: rd_mux = color_rd;
      RGN_VIDEO: rd_mux = video_rd;
      RGN_TILE:  rd_mux = tile_rd;
      default:   rd_mux = 8'h00;
    endcase
  end

  assign tb_hi   = tile_rd[7:4];
  assign tb_lo   = tile_rd[3:0];
  assign sh      = 2'd3 - x_r[1:0];
  assign pal_idx = {color_rd[2:0], tb_hi[sh], tb_lo[sh]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && act == ACT_READ) begin
          state_nxt = S_RD;
        end else if (in_acc && act == ACT_PIXEL) begin
          state_nxt = S_TILE;
        end
      end
      S_RD:    if (out_free) state_nxt = S_IDLE;
      S_TILE:  state_nxt = S_PAL;
      S_PAL:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        rgn_r <= bus_region(in_address);
        x_r   <= in_pixel_x[2:0];
        y_r   <= in_pixel_y[2:0];
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        if (state_r == S_RD) begin
          out_read_data_r <= rd_mux;
          out_red_r       <= 8'h00;
          out_green_r     <= 8'h00;
          out_blue_r      <= 8'h00;
        end else begin
          out_read_data_r <= 8'h00;
          out_red_r       <= pal_red;
          out_green_r     <= pal_green;
          out_blue_r      <= pal_blue;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  tvs_vram u_vram (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mreq),
    .clr_busy (clr_busy),
    .color_rd (color_rd),
    .video_rd (video_rd),
    .tile_rd  (tile_rd)
  );

  tvs_palette u_palette (
    .clk   (clk),
    .we    (prom_we),
    .waddr (in_address[PROM_AW-1:0]),
    .wdata (in_write_data),
    .ridx  (pal_idx),
    .red   (pal_red),
    .green (pal_green),
    .blue  (pal_blue)
  );

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> in_stall)
    else $error("request taken during RAM clear");

  a_no_result_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_action == ACT_WRITE || in_action == ACT_PROM))
      |=> (state_r == S_IDLE))
    else $error("write or PROM load left idle state");

  a_tile_then_pal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TILE) |=> (state_r == S_PAL))
    else $error("tile fetch not followed by palette stage");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result load lost");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tvs_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } answer_t;

  class scanout_shadow;
    bit [7:0] color_mem[CRAM_DEPTH];
    bit [7:0] video_mem[VRAM_DEPTH];
    bit [7:0] tile_mem[TRAM_DEPTH];
    bit [7:0] prom_mem[PROM_DEPTH];
    answer_t pending_answers[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [7:0] dac_level(bit b0, bit b1, bit b2);
      int unsigned sum;
      sum = 0;
      if (b0) sum += RGB_W0;
      if (b1) sum += RGB_W1;
      if (b2) sum += RGB_W2;
      return sum[7:0];
    endfunction

    function logic [7:0] bus_byte(logic [15:0] addr);
      if (addr[15:12] == 4'hF) return tile_mem[addr[11:0]];
      if (addr[15:11] == 5'b11101) return video_mem[addr[10:0]];
      if (addr[15:11] == 5'b11100) return color_mem[addr[10:0]];
      return 8'h00;
    endfunction

    function void note_request(action_t act, logic [15:0] addr, logic [7:0] wd,
                               logic [7:0] x, logic [7:0] y);
      answer_t a;
      int unsigned spot;
      int unsigned color_idx;
      int unsigned tile_idx;
      logic [7:0] tile_byte;
      logic [7:0] shade;
      logic [2:0] hue;
      logic [1:0] pix;
      int s;
      a = '0;
      case (act)
        ACT_WRITE: begin
          if (addr[15:12] == 4'hF) tile_mem[addr[11:0]] = wd;
          else if (addr[15:11] == 5'b11101) video_mem[addr[10:0]] = wd;
          else if (addr[15:11] == 5'b11100) color_mem[addr[10:0]] = wd;
        end
        ACT_READ: begin
          a.read_data = bus_byte(addr);
          pending_answers.push_back(a);
        end
        ACT_PROM: begin
          if (addr < PROM_DEPTH) prom_mem[addr[4:0]] = wd;
        end
        ACT_PIXEL: begin
          spot = (((int'(y) + 16) >> 3) * 64 + 32 + (int'(x) >> 3)) & 'h7FF;
          color_idx = (spot & 'h3F) + ((spot & 'h780) >> 1);
          hue = color_mem[color_idx][2:0];
          tile_idx = (int'(video_mem[spot]) * 16 + (int'(y) & 7) * 2
                      + ((int'(x) & 7) >> 2)) & 'hFFF;
          tile_byte = tile_mem[tile_idx];
          s = int'(x) & 3;
          pix = {tile_byte[7 - s], tile_byte[3 - s]};
          shade = prom_mem[{hue, pix}];
          a.red = dac_level(shade[0], shade[1], shade[2]);
          a.green = dac_level(shade[3], shade[4], shade[5]);
          a.blue = dac_level(1'b0, shade[6], shade[7]);
          pending_answers.push_back(a);
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [7:0] rd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result read_data %h red %h green %h blue %h",
                 $time, rd, r, g, b);
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      compare_field("read_data", want.read_data, rd);
      compare_field("red", want.red, r);
      compare_field("green", want.green, g);
      compare_field("blue", want.blue, b);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_action;
  logic [15:0] in_address;
  logic [7:0] in_write_data;
  logic [7:0] in_pixel_x;
  logic [7:0] in_pixel_y;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_read_data;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  scanout_shadow sb;
  bit calm = 1'b0;
  int busy_items = 0;

  tilemap_video_scanout_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] any_addr();
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] any_line();
    if ($urandom_range(15) == 0) return any_byte();
    return 8'($urandom_range(223));
  endfunction

  // caller sits just after a rising edge; returns just after the accepting edge
  task automatic issue_request(action_t act, logic [15:0] addr, logic [7:0] wd,
                               logic [7:0] x, logic [7:0] y);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_address <= addr;
    in_write_data <= wd;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(act, addr, wd, x, y);
    if (act == ACT_READ || act == ACT_PIXEL || (act == ACT_WRITE && addr >= 16'hE000)
        || (act == ACT_PROM && addr < PROM_DEPTH))
      busy_items++;
  endtask

  // maybe write one cell's video, color and tile bytes, then look at its pixels
  task automatic paint_and_probe();
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] tile_code;
    int spot;
    int color_idx;
    int tile_idx;
    int k;
    px = any_byte() & 8'hFC;
    py = any_line();
    spot = (((int'(py) + 16) >> 3) * 64 + 32 + (int'(px) >> 3)) & 'h7FF;
    color_idx = (spot & 'h3F) + ((spot & 'h780) >> 1);
    tile_code = any_byte();
    tile_idx = (int'(tile_code) * 16 + (int'(py) & 7) * 2 + ((int'(px) & 7) >> 2)) & 'hFFF;
    if ($urandom_range(3) != 0)
      issue_request(ACT_WRITE, 16'hE800 | 16'(spot), tile_code, any_byte(), any_byte());
    if ($urandom_range(3) != 0)
      issue_request(ACT_WRITE, 16'hE000 | 16'(color_idx), any_byte(), any_byte(), any_byte());
    if ($urandom_range(3) != 0)
      issue_request(ACT_WRITE, 16'hF000 | 16'(tile_idx), any_byte(), any_byte(), any_byte());
    for (k = 0; k < $urandom_range(1, 4); k++)
      issue_request(ACT_PIXEL, any_addr(), any_byte(), {px[7:2], 2'(k)}, py);
    if ($urandom_range(3) == 0)
      issue_request(ACT_READ, 16'hF000 | 16'(tile_idx), any_byte(), any_byte(), any_byte());
  endtask

  task automatic stray_request();
    int pick;
    logic [15:0] addr;
    pick = $urandom_range(99);
    addr = ($urandom_range(1) == 0) ? 16'($urandom_range(16'hE000, 16'hFFFF)) : any_addr();
    if (pick < 30)
      issue_request(ACT_READ, addr, any_byte(), any_byte(), any_byte());
    else if (pick < 55)
      issue_request(ACT_WRITE, addr, any_byte(), any_byte(), any_byte());
    else if (pick < 65)
      issue_request(ACT_PROM, ($urandom_range(9) < 7) ? 16'($urandom_range(31)) : any_addr(),
                    any_byte(), any_byte(), any_byte());
    else
      issue_request(ACT_PIXEL, any_addr(), any_byte(), any_byte(), any_line());
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_read_data, out_red, out_green, out_blue);
    out_stall <= !calm && ($urandom_range(99) < 22);
  end

  initial begin
    int i;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_WRITE;
    in_address <= '0;
    in_write_data <= '0;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // every palette entry is loaded before the first pixel request
    for (i = 0; i < PROM_DEPTH; i++)
      issue_request(ACT_PROM, 16'(i), (i == 0) ? 8'hFF : any_byte(), any_byte(), any_byte());

    issue_request(ACT_PIXEL, 16'h0000, 8'h00, 8'd0, 8'd0);
    issue_request(ACT_PIXEL, 16'hFFFF, 8'hFF, 8'd255, 8'd223);
    issue_request(ACT_PIXEL, any_addr(), any_byte(), 8'd128, 8'd255);
    issue_request(ACT_WRITE, 16'hDFFF, 8'hFF, any_byte(), any_byte());
    issue_request(ACT_WRITE, 16'h0000, 8'hFF, any_byte(), any_byte());
    issue_request(ACT_READ, 16'hDFFF, any_byte(), any_byte(), any_byte());
    issue_request(ACT_READ, 16'h0000, any_byte(), any_byte(), any_byte());
    issue_request(ACT_WRITE, 16'hE000, 8'hFF, any_byte(), any_byte());
    issue_request(ACT_WRITE, 16'hE7FF, 8'h81, any_byte(), any_byte());
    issue_request(ACT_WRITE, 16'hE800, 8'hFF, any_byte(), any_byte());
    issue_request(ACT_WRITE, 16'hEFFF, 8'h7E, any_byte(), any_byte());
    issue_request(ACT_WRITE, 16'hF000, 8'hFF, any_byte(), any_byte());
    issue_request(ACT_WRITE, 16'hFFFF, 8'hC3, any_byte(), any_byte());
    issue_request(ACT_READ, 16'hE000, any_byte(), any_byte(), any_byte());
    issue_request(ACT_READ, 16'hE7FF, any_byte(), any_byte(), any_byte());
    issue_request(ACT_READ, 16'hE800, any_byte(), any_byte(), any_byte());
    issue_request(ACT_READ, 16'hEFFF, any_byte(), any_byte(), any_byte());
    issue_request(ACT_READ, 16'hF000, any_byte(), any_byte(), any_byte());
    issue_request(ACT_READ, 16'hFFFF, any_byte(), any_byte(), any_byte());
    issue_request(ACT_PROM, 16'd32, 8'h00, any_byte(), any_byte());
    issue_request(ACT_PROM, 16'hFFFF, 8'h00, any_byte(), any_byte());
    issue_request(ACT_PIXEL, any_addr(), any_byte(), 8'd4, 8'd0);
    issue_request(ACT_PIXEL, any_addr(), any_byte(), 8'd0, 8'd255);

    busy_items = 0;
    while (busy_items < 1000) begin
      calm = (busy_items >= 400 && busy_items < 600);
      if ($urandom_range(9) < 6) paint_and_probe();
      else stray_request();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS tilemap_video_scanout_unit");
    end else begin
      $display("FAIL tilemap_video_scanout_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL tilemap_video_scanout_unit");
    $finish;
  end

endmodule
